// ===== hdl/cpd_pkg.sv =====
// Shared types and constants for the canonical prefix-code decoder.
package cpd_pkg;

    // Stream geometry
    localparam int unsigned MaxCodeBits   = 16;
    localparam int unsigned DirectBits    = 8;
    localparam int unsigned AlphabetDepth = 256;

    // Parse phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_LENGTHS = 3'd2;
    localparam logic [2:0] PH_ALPHA   = 3'd3;
    localparam logic [2:0] PH_CODE    = 3'd4;

    // Engine states
    localparam logic [2:0] S_IN    = 3'd0;
    localparam logic [2:0] S_BUILD = 3'd1;
    localparam logic [2:0] S_PEEK  = 3'd2;
    localparam logic [2:0] S_DIR   = 3'd3;
    localparam logic [2:0] S_LONG  = 3'd4;
    localparam logic [2:0] S_ALR   = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    // Table memory requests
    typedef struct packed {
        logic       a_we;
        logic [7:0] a_waddr;
        logic [7:0] a_wdata;
        logic       a_re;
        logic [7:0] a_raddr;
        logic       d_we;
        logic [7:0] d_waddr;
        logic [3:0] d_wwidth;
        logic [7:0] d_wsym;
        logic       d_re;
        logic [7:0] d_raddr;
    } t_mem_req;

    // Registered read data
    typedef struct packed {
        logic [7:0] a_rdata;
        logic [3:0] d_rwidth;
        logic [7:0] d_rsym;
    } t_mem_rsp;

endpackage

// ===== hdl/cpd_mem.sv =====
// Alphabet memory and direct decode table, with registered reads.
module cpd_mem (
    input  logic              i_clk,
    input  cpd_pkg::t_mem_req i_req,
    output cpd_pkg::t_mem_rsp o_rsp
);

    logic [7:0]  r_alpha [cpd_pkg::AlphabetDepth];
    logic [11:0] r_direct [256];
    logic [7:0]  r_a_rdata;
    logic [11:0] r_d_rdata;

    // alphabet: symbols in canonical order
    always_ff @(posedge i_clk) begin
        if (i_req.a_we) begin
            r_alpha[i_req.a_waddr] <= i_req.a_wdata;
        end
        if (i_req.a_re) begin
            r_a_rdata <= r_alpha[i_req.a_raddr];
        end
    end

    // direct table: {width, symbol}, width 0 escapes to long codes
    always_ff @(posedge i_clk) begin
        if (i_req.d_we) begin
            r_direct[i_req.d_waddr] <= {i_req.d_wwidth, i_req.d_wsym};
        end
        if (i_req.d_re) begin
            r_d_rdata <= r_direct[i_req.d_raddr];
        end
    end

    assign o_rsp.a_rdata  = r_a_rdata;
    assign o_rsp.d_rwidth = r_d_rdata[11:8];
    assign o_rsp.d_rsym   = r_d_rdata[7:0];

endmodule

// ===== hdl/canonical_prefix_code_decoder_top.sv =====
// Canonical prefix-code decoder: header parse, table build and symbol decode.
// Header, length and alphabet words are taken one per cycle, then all 256 direct table
// entries are built with the input stalled. A code word takes an accept step, a peek and
// lookup per short symbol, a peek, lookup, one trial per code length tried past 8 and an
// alphabet read per long symbol, a closing miss (none at stream end) and a flush step,
// which waits for a free output slot. Symbols pass the pending word, then the output word.
module canonical_prefix_code_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // in_byte
    input  logic       i_s_tuser,   // stream_start
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // sym_byte
    output logic       o_m_tlast,   // run_last
    output logic [1:0] o_m_tuser    // stream_last, format_error
);

    cpd_pkg::t_mem_req mem_req;
    cpd_pkg::t_mem_rsp mem_rsp;

    logic [2:0]  r_st, n_st;
    logic [2:0]  r_phase, n_phase;
    logic [8:0]  r_cnt, n_cnt;
    logic [23:0] r_rem, n_rem;
    logic [7:0]  r_last, n_last;
    logic        r_delta, n_delta;
    logic [4:0]  r_used, n_used;
    logic [9:0]  r_alpha, n_alpha;
    logic [16:0] r_prev, n_prev;
    logic [23:0] r_win, n_win;
    logic [4:0]  r_fill, n_fill;
    logic [7:0]  r_be, n_be;
    logic [4:0]  r_len, n_len;
    logic [16:0] r_limit [cpd_pkg::MaxCodeBits];
    logic [7:0]  r_offset [cpd_pkg::MaxCodeBits];
    logic        r_bv_d;
    logic [7:0]  r_be_d;
    logic [3:0]  r_bw_d;
    logic        r_pv, n_pv;
    logic [7:0]  r_psym, n_psym;
    logic        r_pslast, n_pslast;
    logic        r_perr, n_perr;
    logic        r_ov, n_ov;
    logic [7:0]  r_osym, n_osym;
    logic        r_olast, n_olast;
    logic        r_oslast, n_oslast;
    logic        r_oerr, n_oerr;

    logic        acc, can_push;
    logic        lw_en;
    logic [3:0]  lw_idx;
    logic [17:0] lim;
    logic [9:0]  asum;
    logic        want_sym, err_req, cons_en;
    logic [7:0]  sym_raw, sym_val;
    logic [4:0]  cons_n;
    logic [23:0] rem1;
    logic [7:0]  peek;
    logic [3:0]  bld_w;
    logic [7:0]  bld_idx;
    logic [4:0]  top_w;
    logic [7:0]  bld_code;
    logic [15:0] lcode;
    logic [23:0] lshift;
    logic [3:0]  lidx;
    logic [4:0]  len_m1;

    assign acc        = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_st == cpd_pkg::S_IN);
    assign can_push   = !r_pv || !r_ov || i_m_tready;

    // direct table entry for the build sweep
    always_comb begin
        top_w   = (r_used < 5'd8) ? r_used : 5'd8;
        bld_w   = '0;
        bld_idx = '0;
        bld_code = '0;
        for (int w = 8; w >= 1; w--) begin
            bld_code = r_be >> (8 - w);
            if (5'(w) <= top_w && {9'd0, bld_code} < r_limit[w - 1]) begin
                bld_w   = 4'(w);
                bld_idx = bld_code + r_offset[w - 1];
            end
        end
    end

    // peek at the next eight window bits
    always_comb begin
        if (r_fill >= 5'd8) begin
            peek = 8'(r_win >> (r_fill - 5'd8));
        end else begin
            peek = 8'(r_win << (5'd8 - r_fill));
        end
    end

    // long code of the current trial length
    assign len_m1 = r_len - 5'd1;
    assign lidx   = len_m1[3:0];
    assign lshift = r_win >> (r_fill - r_len);
    assign lcode  = lshift[15:0] & (16'hFFFF >> (5'd16 - r_len));

    // header and table words
    assign lw_idx = r_cnt[3:0];
    assign lim    = {r_prev, 1'b0} + {10'd0, i_s_tdata};
    assign asum   = r_alpha + {2'd0, i_s_tdata};
    assign rem1   = r_rem - 24'd1;
    assign sym_val = r_delta ? (r_last + sym_raw) : sym_raw;

    // main sequencer
    always_comb begin
        n_st = r_st;         n_phase = r_phase;   n_cnt = r_cnt;
        n_rem = r_rem;       n_last = r_last;     n_delta = r_delta;
        n_used = r_used;     n_alpha = r_alpha;   n_prev = r_prev;
        n_win = r_win;       n_fill = r_fill;     n_be = r_be;
        n_len = r_len;
        n_pv = r_pv;         n_psym = r_psym;     n_pslast = r_pslast;
        n_perr = r_perr;
        n_ov = r_ov && !i_m_tready;
        n_osym = r_osym;     n_olast = r_olast;   n_oslast = r_oslast;
        n_oerr = r_oerr;
        mem_req  = '0;
        lw_en    = 1'b0;
        want_sym = 1'b0;
        err_req  = 1'b0;
        cons_en  = 1'b0;
        cons_n   = '0;
        sym_raw  = '0;

        mem_req.d_we     = r_bv_d;
        mem_req.d_waddr  = r_be_d;
        mem_req.d_wwidth = r_bw_d;
        mem_req.d_wsym   = mem_rsp.a_rdata;

        case (r_st)
            cpd_pkg::S_IN: begin
                if (acc) begin
                    if (i_s_tuser) begin
                        n_phase = cpd_pkg::PH_HEADER;
                        n_cnt = 9'd1;
                        n_win = '0;  n_fill = '0;  n_rem = '0;  n_last = '0;
                        n_delta = 1'b0;  n_used = '0;  n_alpha = '0;  n_prev = '0;
                    end else begin
                        case (r_phase)
                            cpd_pkg::PH_HEADER: begin
                                if (r_cnt < 9'd4) begin
                                    case (r_cnt[1:0])
                                        2'd1:    n_rem[7:0]   = r_rem[7:0]   | i_s_tdata;
                                        2'd2:    n_rem[15:8]  = r_rem[15:8]  | i_s_tdata;
                                        default: n_rem[23:16] = r_rem[23:16] | i_s_tdata;
                                    endcase
                                    n_cnt = r_cnt + 9'd1;
                                end else begin
                                    n_delta = i_s_tdata[7];
                                    if (i_s_tdata[6:0] > 7'(cpd_pkg::MaxCodeBits)) begin
                                        err_req = 1'b1;
                                    end else begin
                                        n_used = i_s_tdata[4:0];
                                        n_cnt  = '0;
                                        n_prev = '0;
                                        if (i_s_tdata[6:0] == 7'd0) begin
                                            n_st = cpd_pkg::S_BUILD;
                                            n_be = '0;
                                        end else begin
                                            n_phase = cpd_pkg::PH_LENGTHS;
                                        end
                                    end
                                end
                            end
                            cpd_pkg::PH_LENGTHS: begin
                                lw_en = 1'b1;
                                if (lim > (18'd1 << ({1'b0, lw_idx} + 5'd1)) ||
                                    asum > 10'(cpd_pkg::AlphabetDepth)) begin
                                    err_req = 1'b1;
                                end else begin
                                    n_alpha = asum;
                                    n_prev  = lim[16:0];
                                    n_cnt   = r_cnt + 9'd1;
                                    if (n_cnt >= {4'd0, r_used}) begin
                                        n_cnt = '0;
                                        if (asum == 10'd0) begin
                                            n_st = cpd_pkg::S_BUILD;
                                            n_be = '0;
                                        end else begin
                                            n_phase = cpd_pkg::PH_ALPHA;
                                        end
                                    end
                                end
                            end
                            cpd_pkg::PH_ALPHA: begin
                                mem_req.a_we    = 1'b1;
                                mem_req.a_waddr = r_cnt[7:0];
                                mem_req.a_wdata = i_s_tdata;
                                n_cnt = r_cnt + 9'd1;
                                if ({1'b0, n_cnt} >= r_alpha) begin
                                    n_st = cpd_pkg::S_BUILD;
                                    n_be = '0;
                                end
                            end
                            cpd_pkg::PH_CODE: begin
                                n_win  = {r_win[15:0], i_s_tdata};
                                n_fill = r_fill + 5'd8;
                                n_st   = cpd_pkg::S_PEEK;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            cpd_pkg::S_BUILD: begin
                mem_req.a_re    = 1'b1;
                mem_req.a_raddr = bld_idx;
                n_be = r_be + 8'd1;
                if (r_be == 8'hFF) begin
                    n_st    = cpd_pkg::S_IN;
                    n_phase = (r_rem == 24'd0) ? cpd_pkg::PH_IDLE : cpd_pkg::PH_CODE;
                end
            end
            cpd_pkg::S_PEEK: begin
                mem_req.d_re    = 1'b1;
                mem_req.d_raddr = peek;
                n_st = cpd_pkg::S_DIR;
            end
            cpd_pkg::S_DIR: begin
                if (mem_rsp.d_rwidth != 4'd0) begin
                    if ({1'b0, mem_rsp.d_rwidth} > r_fill) begin
                        n_st = cpd_pkg::S_FLUSH;
                    end else begin
                        want_sym = 1'b1;
                        sym_raw  = mem_rsp.d_rsym;
                        cons_n   = {1'b0, mem_rsp.d_rwidth};
                    end
                end else if (r_fill < 5'd8) begin
                    n_st = cpd_pkg::S_FLUSH;
                end else begin
                    n_len = 5'd9;
                    n_st  = cpd_pkg::S_LONG;
                end
            end
            cpd_pkg::S_LONG: begin
                if (r_len > r_used) begin
                    err_req = 1'b1;
                end else if (r_fill < r_len) begin
                    n_st = cpd_pkg::S_FLUSH;
                end else if ({1'b0, lcode} < r_limit[lidx]) begin
                    mem_req.a_re    = 1'b1;
                    mem_req.a_raddr = lcode[7:0] + r_offset[lidx];
                    cons_en = 1'b1;
                    cons_n  = r_len;
                    n_st    = cpd_pkg::S_ALR;
                end else begin
                    n_len = r_len + 5'd1;
                end
            end
            cpd_pkg::S_ALR: begin
                want_sym = 1'b1;
                sym_raw  = mem_rsp.a_rdata;
            end
            cpd_pkg::S_FLUSH: begin
                if (!r_pv) begin
                    n_st = cpd_pkg::S_IN;
                end else if (!r_ov || i_m_tready) begin
                    n_ov = 1'b1;  n_osym = r_psym;  n_olast = 1'b1;
                    n_oslast = r_pslast;  n_oerr = r_perr;
                    n_pv = 1'b0;
                    n_st = cpd_pkg::S_IN;
                end
            end
            default: n_st = cpd_pkg::S_IN;
        endcase

        // new symbol or error into the pending word
        if ((want_sym || err_req) && can_push) begin
            if (r_pv) begin
                n_ov = 1'b1;  n_osym = r_psym;  n_olast = 1'b0;
                n_oslast = r_pslast;  n_oerr = r_perr;
            end
            n_pv = 1'b1;
            if (err_req) begin
                n_psym = '0;  n_pslast = 1'b0;  n_perr = 1'b1;
                n_phase = cpd_pkg::PH_IDLE;
                n_st = cpd_pkg::S_FLUSH;
            end else begin
                n_psym = sym_val;  n_pslast = (rem1 == 24'd0);  n_perr = 1'b0;
                n_last = sym_val;
                n_rem  = rem1;
                cons_en = 1'b1;
                if (rem1 == 24'd0) begin
                    n_phase = cpd_pkg::PH_IDLE;
                    n_st = cpd_pkg::S_FLUSH;
                end else begin
                    n_st = cpd_pkg::S_PEEK;
                end
            end
        end

        // drop consumed bits from the window
        if (cons_en) begin
            n_fill = r_fill - cons_n;
            n_win  = r_win & ((24'd1 << n_fill) - 24'd1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= cpd_pkg::S_IN;  r_phase <= cpd_pkg::PH_IDLE;  r_cnt <= '0;
            r_rem <= '0;  r_last <= '0;  r_delta <= 1'b0;  r_used <= '0;
            r_alpha <= '0;  r_prev <= '0;  r_win <= '0;  r_fill <= '0;
            r_be <= '0;  r_len <= '0;  r_bv_d <= 1'b0;
            r_pv <= 1'b0;  r_ov <= 1'b0;
        end else begin
            r_st <= n_st;  r_phase <= n_phase;  r_cnt <= n_cnt;
            r_rem <= n_rem;  r_last <= n_last;  r_delta <= n_delta;  r_used <= n_used;
            r_alpha <= n_alpha;  r_prev <= n_prev;  r_win <= n_win;  r_fill <= n_fill;
            r_be <= n_be;  r_len <= n_len;
            r_bv_d <= (r_st == cpd_pkg::S_BUILD);
            r_pv <= n_pv;  r_ov <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_be_d <= r_be;
        r_bw_d <= bld_w;
        r_psym <= n_psym;  r_pslast <= n_pslast;  r_perr <= n_perr;
        r_osym <= n_osym;  r_olast <= n_olast;  r_oslast <= n_oslast;  r_oerr <= n_oerr;
        if (lw_en) begin
            r_limit[lw_idx]  <= lim[16:0];
            r_offset[lw_idx] <= r_alpha[7:0] - {r_prev[6:0], 1'b0};
        end
    end

    cpd_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_osym;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = {r_oerr, r_oslast};

    // a new word is only taken once no symbol is left in the pending word
    a_pend_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == cpd_pkg::S_IN) |-> !r_pv)
        else $error("pending word left when taking input");

    // window never exceeds its bit width
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 5'd23)
        else $error("bit window overfilled");

    // error words carry no symbol and no stream end
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata == 8'd0 && !o_m_tuser[0] && o_m_tlast))
        else $error("malformed error word");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the canonical prefix-code decoder: stream generation and result checking.
`timescale 1ns / 1ps

// Expected decoded words, queued per accepted input word
class cpd_scoreboard;
    logic [7:0] exp_sym[$];
    logic       exp_run_last[$];
    logic       exp_str_last[$];
    logic       exp_err[$];
    int         n_err;

    // Decoder state
    logic [7:0]  alpha[256];
    logic [3:0]  dwidth[256];
    logic [7:0]  dsym[256];
    logic [31:0] loff[16];
    logic [31:0] llim[16];
    logic [23:0] win;
    int          fill;
    logic [23:0] remain;
    logic [7:0]  last_sym;
    logic [2:0]  phase;
    int          pcnt;
    bit          delta;
    int          nlen;
    int          asize;

    function new();
        n_err  = 0;
        phase  = cpd_pkg::PH_IDLE;
        win    = '0;
        fill   = 0;
        remain = '0;
        last_sym = '0;
        pcnt   = 0;
        delta  = 0;
        nlen   = 0;
        asize  = 0;
    endfunction

    function int pending();
        return exp_sym.size();
    endfunction

    function void push(logic [7:0] s, bit sl, bit e);
        exp_sym.push_back(s);
        exp_run_last.push_back(1'b0);
        exp_str_last.push_back(sl);
        exp_err.push_back(e);
    endfunction

    function void build_direct();
        int top;
        int code;
        top = (nlen < 8) ? nlen : 8;
        for (int e = 0; e < 256; e++) begin
            dwidth[e] = '0;
            dsym[e] = '0;
            for (int w = 1; w <= top; w++) begin
                code = e >> (8 - w);
                if (code < llim[w-1]) begin
                    dwidth[e] = 4'(w);
                    dsym[e] = alpha[(code + loff[w-1]) & 8'hff];
                    break;
                end
            end
        end
    endfunction

    function void finish_tables();
        build_direct();
        phase = (remain == 0) ? cpd_pkg::PH_IDLE : cpd_pkg::PH_CODE;
    endfunction

    function void finish_lengths();
        pcnt = 0;
        if (asize == 0) finish_tables();
        else phase = cpd_pkg::PH_ALPHA;
    endfunction

    function void take(int n);
        fill -= n;
        win &= (24'd1 << fill) - 1;
    endfunction

    // 1 = symbol, 0 = more bits, -1 = bad code
    function int decode_sym(output logic [7:0] s);
        int peek;
        int dw;
        int code;
        s = 0;
        if (fill >= 8) peek = (win >> (fill - 8)) & 8'hff;
        else peek = (win << (8 - fill)) & 8'hff;
        dw = dwidth[peek];
        if (dw != 0) begin
            if (dw > fill) return 0;
            s = dsym[peek];
            take(dw);
            return 1;
        end
        if (fill < 8) return 0;
        for (int len = 9; len <= nlen && len <= 16; len++) begin
            if (fill < len) return 0;
            code = (win >> (fill - len)) & ((1 << len) - 1);
            if (code < llim[len-1]) begin
                s = alpha[(code + loff[len-1]) & 8'hff];
                take(len);
                return 1;
            end
        end
        return -1;
    endfunction

    // Note one accepted input word
    function void note_input(logic [7:0] b, logic start);
        int base;
        int i;
        int r;
        logic [31:0] prev;
        logic [31:0] lim;
        logic [7:0] s;
        bit err;
        base = exp_sym.size();
        err = 0;
        if (start) begin
            phase = cpd_pkg::PH_HEADER;
            pcnt = 1;
            win = 0;
            fill = 0;
            remain = 0;
            last_sym = 0;
            delta = 0;
            nlen = 0;
            asize = 0;
            return;
        end
        case (phase)
            cpd_pkg::PH_HEADER: begin
                if (pcnt < 4) begin
                    remain |= 24'(b) << (8 * (pcnt - 1));
                    pcnt++;
                end else begin
                    delta = b[7];
                    i = b & 8'h7f;
                    if (i > 16) err = 1;
                    else begin
                        nlen = i;
                        pcnt = 0;
                        if (i == 0) finish_lengths();
                        else phase = cpd_pkg::PH_LENGTHS;
                    end
                end
            end
            cpd_pkg::PH_LENGTHS: begin
                i = pcnt & 15;
                prev = i ? llim[i-1] : 0;
                loff[i] = (asize - 2 * prev) & 16'hffff;
                lim = 2 * prev + b;
                llim[i] = lim;
                asize += b;
                if (lim > (32'd1 << (i + 1)) || asize > 256) err = 1;
                else begin
                    pcnt++;
                    if (pcnt >= nlen) finish_lengths();
                end
            end
            cpd_pkg::PH_ALPHA: begin
                alpha[pcnt & 8'hff] = b;
                pcnt++;
                if (pcnt >= asize) finish_tables();
            end
            cpd_pkg::PH_CODE: begin
                win = {win[15:0], b};
                fill += 8;
                while (phase == cpd_pkg::PH_CODE) begin
                    r = decode_sym(s);
                    if (r == 0) break;
                    if (r < 0) begin
                        err = 1;
                        break;
                    end
                    if (delta) s = last_sym + s;
                    last_sym = s;
                    remain = remain - 1;
                    if (remain == 0) begin
                        phase = cpd_pkg::PH_IDLE;
                        push(s, 1, 0);
                    end else push(s, 0, 0);
                end
            end
            default: ;
        endcase
        if (err) begin
            phase = cpd_pkg::PH_IDLE;
            push(8'h00, 0, 1);
        end
        if (exp_sym.size() > base) exp_run_last[$] = 1'b1;
    endfunction

    // Check one accepted output word
    task check_word(logic [7:0] s, logic rl, logic sl, logic e);
        if (exp_sym.size() == 0) begin
            report_miss($sformatf("unexpected word sym=%h", s));
            return;
        end
        if (s !== exp_sym[0] || rl !== exp_run_last[0] || sl !== exp_str_last[0] ||
            e !== exp_err[0])
            report_miss($sformatf("got sym=%h rl=%b sl=%b err=%b, want %h %b %b %b",
                s, rl, sl, e, exp_sym[0], exp_run_last[0], exp_str_last[0], exp_err[0]));
        void'(exp_sym.pop_front());
        void'(exp_run_last.pop_front());
        void'(exp_str_last.pop_front());
        void'(exp_err.pop_front());
    endtask

    task report_miss(string msg);
        n_err++;
        $display("MISMATCH: %s", msg);
    endtask
endclass

module tb_top;
    localparam int WatchLimit = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // in_byte
    logic       i_s_tuser;   // stream_start
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // sym_byte
    logic       o_m_tlast;   // run_last
    logic [1:0] o_m_tuser;   // stream_last, format_error

    cpd_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  quiet_cycles;
    int  n_items;

    canonical_prefix_code_decoder_top i_dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stall, check on handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_m_tvalid && i_m_tready)
                sb.check_word(o_m_tdata, o_m_tlast, o_m_tuser[0], o_m_tuser[1]);
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Send one input word; valid stays high into the next word unless idling
    task automatic send_word(logic [7:0] b, logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= start;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(b, start);
        n_items++;
    endtask

    // Stop sending and wait for every expected word
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // One full stream; counts per length given, alphabet random, codes random
    task automatic send_stream(int out_len, bit dlt, int lens[$], int ncode_bytes,
                               bit well_formed);
        int total;
        send_word(8'($urandom_range(255)), 1'b1);
        send_word(out_len[7:0], 1'b0);
        send_word(out_len[15:8], 1'b0);
        send_word(out_len[23:16], 1'b0);
        send_word({dlt, 7'(lens.size())}, 1'b0);
        total = 0;
        foreach (lens[k]) begin
            send_word(8'(lens[k]), 1'b0);
            total += lens[k];
        end
        if (!well_formed) total = $urandom_range(total);
        for (int k = 0; k < total; k++) send_word(8'($urandom_range(255)), 1'b0);
        for (int k = 0; k < ncode_bytes; k++) send_word(8'($urandom_range(255)), 1'b0);
    endtask

    // Random code lengths, roughly filling the Kraft space
    task automatic rand_lengths(int maxlen, output int lens[$]);
        int avail;
        int c;
        lens = {};
        avail = 2;
        for (int l = 1; l <= maxlen; l++) begin
            if (l == maxlen) c = avail;
            else c = $urandom_range(avail > 3 ? 3 : avail);
            if (l == maxlen && c == 0) c = 1;
            lens.push_back(c);
            avail = (avail - c) * 2;
            if (avail > 12) avail = 12;
        end
    endtask

    initial begin
        int lens[$];
        int ml;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        n_items = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle byte, zero length, two 1-bit codes, delta mode
        send_word(8'hff, 1'b0);
        send_stream(0, 0, {2}, 0, 1);
        send_stream(9, 1, {2}, 2, 1);
        drain();
        // Too many lengths, oversubscription
        send_word(8'h00, 1'b1);
        repeat (3) send_word(8'h00, 1'b0);
        send_word(8'h11, 1'b0);
        send_stream(5, 0, {3}, 0, 1);
        // Alphabet too big: 255 codes of 9 bits, 2 of 10 bits
        send_word(8'h00, 1'b1);
        send_word(8'h05, 1'b0);
        repeat (2) send_word(8'h00, 1'b0);
        send_word(8'h0a, 1'b0);
        repeat (8) send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h02, 1'b0);
        // Invalid code: only one 16-bit code used, then random code bits
        send_stream(2, 0, {0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1}, 3, 1);
        // Long codes with restart mid-stream
        send_stream(300, 0, {1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2}, 2, 1);
        drain();

        // Random phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            while (n_items < 90 + 50 * (ph + 1)) begin
                ml = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
                rand_lengths(ml, lens);
                if ($urandom_range(9) == 0)
                    send_stream($urandom_range(40), 1'($urandom), lens,
                                $urandom_range(10), 0);
                else
                    send_stream($urandom_range(1, 40), 1'($urandom), lens,
                                $urandom_range(4, 14), 1);
                if ($urandom_range(3) == 0) send_word(8'($urandom_range(255)), 1'b0);
            end
            drain();
        end

        drain();
        repeat (600) @(posedge i_clk);
        if (sb.n_err == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
